### design/phase_weighted_projection_sum_core_defines.svh
`ifndef PHASE_WEIGHTED_PROJECTION_SUM_CORE_DEFINES_SVH
`define PHASE_WEIGHTED_PROJECTION_SUM_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PWPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PWPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pwps_pkg.sv
package pwps_pkg;

    localparam int OPERAND_BITS  = 16;
    localparam int FRAC_BITS     = OPERAND_BITS - 2;
    localparam int CELL_BITS     = 7;
    localparam int KPOINT_BITS   = 16;
    localparam int NORM_BITS     = 16;
    localparam int NORM_FRAC     = 15;
    localparam int ANG_BITS      = 16;
    localparam int TAB_ADDR_BITS = 10;
    localparam int ACC_BITS      = 48;
    localparam int SUM_BITS      = 32;
    localparam int FIFO_DEPTH    = 4;

    localparam int QUARTER       = (2 ** TAB_ADDR_BITS) / 4;
    localparam int QW_BITS       = FRAC_BITS + 1;
    localparam int Q30           = 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef struct packed {
        logic signed [OPERAND_BITS-1:0] coef_real;
        logic signed [OPERAND_BITS-1:0] coef_imag;
        logic signed [OPERAND_BITS-1:0] overlap;
        logic signed [CELL_BITS-1:0]    cell_a;
        logic signed [CELL_BITS-1:0]    cell_b;
        logic signed [CELL_BITS-1:0]    cell_c;
        logic                           last;
    } t_in_item;

    typedef struct packed {
        logic signed [OPERAND_BITS-1:0] coef_real;
        logic signed [OPERAND_BITS-1:0] coef_imag;
        logic signed [OPERAND_BITS-1:0] overlap;
        logic [TAB_ADDR_BITS-1:0]       addr;
        logic                           last;
    } t_fe_item;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum_real;
        logic signed [SUM_BITS-1:0] sum_imag;
        logic                       overflow;
    } t_result;

    typedef logic [QW_BITS-1:0] t_qw_tab [0:QUARTER];

    // two taylor orders: t * x^2 in q30
    function automatic logic [63:0] sq_step(logic [63:0] t, logic [63:0] x);
        logic [63:0] u;
        u = (t * x) >> Q30;
        return (u * x) >> Q30;
    endfunction

    // quarter-wave sine entry, q30 series rounded half up to q1.14
    function automatic logic [QW_BITS-1:0] qw_entry(int unsigned r);
        logic [63:0]        x;
        logic [63:0]        t;
        logic [63:0]        rs;
        logic signed [63:0] s;
        x = (TWO_PI_Q30 * 64'(r)) >> TAB_ADDR_BITS;
        t = x;
        s = signed'(x);
        t = sq_step(t, x) / 64'd6;   s = s - signed'(t);
        t = sq_step(t, x) / 64'd20;  s = s + signed'(t);
        t = sq_step(t, x) / 64'd42;  s = s - signed'(t);
        t = sq_step(t, x) / 64'd72;  s = s + signed'(t);
        t = sq_step(t, x) / 64'd110; s = s - signed'(t);
        t = sq_step(t, x) / 64'd156; s = s + signed'(t);
        t = sq_step(t, x) / 64'd210; s = s - signed'(t);
        t = sq_step(t, x) / 64'd272; s = s + signed'(t);
        t = sq_step(t, x) / 64'd342; s = s - signed'(t);
        t = sq_step(t, x) / 64'd420; s = s + signed'(t);
        t = sq_step(t, x) / 64'd506; s = s - signed'(t);
        t = sq_step(t, x) / 64'd600; s = s + signed'(t);
        if (s < 0) begin
            s = '0;
        end
        rs = (unsigned'(s) + (64'd1 << (Q30 - FRAC_BITS - 1))) >> (Q30 - FRAC_BITS);
        return rs[QW_BITS-1:0];
    endfunction

    function automatic t_qw_tab build_qw_tab();
        t_qw_tab tab;
        for (int r = 0; r <= QUARTER; r++) begin
            tab[r] = qw_entry(r);
        end
        return tab;
    endfunction

    localparam t_qw_tab QW_TAB = build_qw_tab();

    // full-wave sine from the quarter table by symmetry
    function automatic logic signed [OPERAND_BITS-1:0] sine_at(
        logic [TAB_ADDR_BITS-1:0] addr
    );
        logic [1:0]                     quad;
        logic [TAB_ADDR_BITS-3:0]       rem;
        logic [TAB_ADDR_BITS-2:0]       idx;
        logic signed [OPERAND_BITS-1:0] mag;
        quad = addr[TAB_ADDR_BITS-1 -: 2];
        rem  = addr[TAB_ADDR_BITS-3:0];
        if (quad[0]) begin
            idx = (TAB_ADDR_BITS-1)'(QUARTER) - {1'b0, rem};
        end else begin
            idx = {1'b0, rem};
        end
        mag = signed'(OPERAND_BITS'(QW_TAB[idx]));
        return quad[1] ? -mag : mag;
    endfunction

endpackage

### design/pwps_front.sv
module pwps_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  pwps_pkg::t_in_item                   i_item,
    input  logic signed [pwps_pkg::KPOINT_BITS-1:0] i_kpoint_a,
    input  logic signed [pwps_pkg::KPOINT_BITS-1:0] i_kpoint_b,
    input  logic signed [pwps_pkg::KPOINT_BITS-1:0] i_kpoint_c,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output pwps_pkg::t_fe_item                   o_item
);

    localparam int PROD_BITS = pwps_pkg::KPOINT_BITS + pwps_pkg::CELL_BITS;
    localparam int DOT_BITS  = PROD_BITS + 2;

    logic                        r_valid;
    pwps_pkg::t_in_item          r_item;
    logic signed [PROD_BITS-1:0] r_prod_a;
    logic signed [PROD_BITS-1:0] r_prod_b;
    logic signed [PROD_BITS-1:0] r_prod_c;
    logic signed [DOT_BITS-1:0]  dot;
    logic [DOT_BITS-1:0]         neg_dot;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item   <= i_item;
            r_prod_a <= $signed(i_kpoint_a) * $signed(i_item.cell_a);
            r_prod_b <= $signed(i_kpoint_b) * $signed(i_item.cell_b);
            r_prod_c <= $signed(i_kpoint_c) * $signed(i_item.cell_c);
        end
    end

    // phase in turns is minus the dot product, kept modulo one turn
    assign dot = DOT_BITS'(r_prod_a) + DOT_BITS'(r_prod_b) + DOT_BITS'(r_prod_c);
    assign neg_dot = -dot;

    always_comb begin
        o_item.coef_real = r_item.coef_real;
        o_item.coef_imag = r_item.coef_imag;
        o_item.overlap   = r_item.overlap;
        o_item.addr      = neg_dot[pwps_pkg::ANG_BITS-1 -: pwps_pkg::TAB_ADDR_BITS];
        o_item.last      = r_item.last;
    end

endmodule

### design/pwps_fifo.sv
`include "phase_weighted_projection_sum_core_defines.svh"

module pwps_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_valid,
    output logic               o_wr_ready,
    input  pwps_pkg::t_fe_item i_wr_item,
    output logic               o_rd_valid,
    input  logic               i_rd_ready,
    output pwps_pkg::t_fe_item o_rd_item
);

    localparam int DEPTH = pwps_pkg::FIFO_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    pwps_pkg::t_fe_item r_mem [0:DEPTH-1];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW:0]        r_count;
    logic               do_push;
    logic               do_pop;

    assign o_wr_ready = (r_count != (AW+1)'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign do_push    = i_wr_valid && o_wr_ready;
    assign do_pop     = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    `PWPS_ASSERT_NOW(a_cnt_max, 1'b1, r_count <= (AW+1)'(DEPTH), "queue count above depth")
    `PWPS_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "push lost")
    `PWPS_ASSERT_NEXT(a_cnt_dn, do_pop && !do_push, r_count == $past(r_count) - 1'b1, "pop lost")

endmodule

### design/pwps_back.sv
`include "phase_weighted_projection_sum_core_defines.svh"

module pwps_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    output logic                               o_q_ready,
    input  pwps_pkg::t_fe_item                 i_q_item,
    input  logic [pwps_pkg::NORM_BITS-1:0]     i_norm_scale,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output pwps_pkg::t_result                  o_res
);

    localparam int OPB       = pwps_pkg::OPERAND_BITS;
    localparam int FRAC      = pwps_pkg::FRAC_BITS;
    localparam int ACCB      = pwps_pkg::ACC_BITS;
    localparam int SUMB      = pwps_pkg::SUM_BITS;
    localparam int NFRAC     = pwps_pkg::NORM_FRAC;
    localparam int P2_BITS   = 2 * OPB;
    localparam int TR_BITS   = P2_BITS + 1 - FRAC;
    localparam int TERM_BITS = TR_BITS + OPB;
    localparam int SPLIT     = 32;
    localparam int PH_BITS   = ACCB - SPLIT + pwps_pkg::NORM_BITS;
    localparam int PL_BITS   = SPLIT + pwps_pkg::NORM_BITS;
    localparam int R_BITS    = SUMB + 3;

    localparam logic signed [P2_BITS:0] ROT_HALF = (P2_BITS+1)'(2 ** (FRAC - 1));
    localparam logic [PL_BITS:0]        NORM_HALF = (PL_BITS+1)'(2 ** (NFRAC - 1));
    localparam logic [PH_BITS-1:0]      PH_LIM = PH_BITS'(2 ** NFRAC);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_TERM = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_MAG  = 3'd5;
    localparam logic [2:0] ST_NMUL = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic signed [OPB-1:0]       r_sin;
    logic signed [OPB-1:0]       r_cos;
    logic signed [OPB-1:0]       r_wr;
    logic signed [OPB-1:0]       r_wi;
    logic signed [OPB-1:0]       r_ov;
    logic                        r_last;
    logic signed [P2_BITS-1:0]   r_p_cr;
    logic signed [P2_BITS-1:0]   r_p_si;
    logic signed [P2_BITS-1:0]   r_p_sr;
    logic signed [P2_BITS-1:0]   r_p_ci;
    logic signed [TR_BITS-1:0]   r_tr;
    logic signed [TR_BITS-1:0]   r_ti;
    logic signed [TERM_BITS-1:0] r_term_re;
    logic signed [TERM_BITS-1:0] r_term_im;
    logic signed [ACCB-1:0]      r_acc_re;
    logic signed [ACCB-1:0]      r_acc_im;
    logic [ACCB-1:0]             r_mag_re;
    logic [ACCB-1:0]             r_mag_im;
    logic                        r_neg_re;
    logic                        r_neg_im;
    logic [PH_BITS-1:0]          r_ph_re;
    logic [PH_BITS-1:0]          r_ph_im;
    logic [PL_BITS-1:0]          r_pl_re;
    logic [PL_BITS-1:0]          r_pl_im;
    logic                        r_res_valid;
    pwps_pkg::t_result           r_res;
    logic signed [P2_BITS:0]     rot_re;
    logic signed [P2_BITS:0]     rot_im;
    logic [SUMB:0]               sc_re;
    logic [SUMB:0]               sc_im;
    logic                        out_free;

    function automatic logic signed [ACCB-1:0] sat_add(
        logic signed [ACCB-1:0]      acc,
        logic signed [TERM_BITS-1:0] term
    );
        logic signed [ACCB:0] s;
        s = (ACCB+1)'(acc) + (ACCB+1)'(term);
        if (s[ACCB] != s[ACCB-1]) begin
            return s[ACCB] ? {1'b1, {(ACCB-1){1'b0}}} : {1'b0, {(ACCB-1){1'b1}}};
        end
        return s[ACCB-1:0];
    endfunction

    // norm scaling of a magnitude, round half away from zero, clamp; msb is overflow
    function automatic logic [SUMB:0] scale_out(
        logic [PH_BITS-1:0] ph,
        logic [PL_BITS-1:0] pl,
        logic               neg
    );
        logic [SUMB-1:0]   lim;
        logic [PL_BITS:0]  pl_rnd;
        logic [R_BITS-1:0] r;
        logic [SUMB-1:0]   val;
        logic              ovf;
        lim    = neg ? {1'b1, {(SUMB-1){1'b0}}} : {1'b0, {(SUMB-1){1'b1}}};
        pl_rnd = (PL_BITS+1)'(pl) + NORM_HALF;
        r      = (R_BITS'(ph[NFRAC-1:0]) << (SPLIT - NFRAC)) + R_BITS'(pl_rnd >> NFRAC);
        ovf    = 1'b0;
        val    = r[SUMB-1:0];
        if (ph >= PH_LIM || r > R_BITS'(lim)) begin
            ovf = 1'b1;
            val = lim;
        end
        return {ovf, neg ? -val : val};
    endfunction

    assign o_q_ready   = (r_state == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign out_free    = !r_res_valid || i_res_ready;

    assign rot_re = (P2_BITS+1)'(r_p_cr) + (P2_BITS+1)'(r_p_si) + ROT_HALF;
    assign rot_im = (P2_BITS+1)'(r_p_sr) - (P2_BITS+1)'(r_p_ci) + ROT_HALF;
    assign sc_re  = scale_out(r_ph_re, r_pl_re, r_neg_re);
    assign sc_im  = scale_out(r_ph_im, r_pl_im, r_neg_im);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_RND;
            ST_RND:  n_state = ST_TERM;
            ST_TERM: n_state = ST_ACC;
            ST_ACC:  n_state = r_last ? ST_MAG : ST_IDLE;
            ST_MAG:  n_state = ST_NMUL;
            ST_NMUL: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (r_state == ST_ACC) begin
                r_acc_re <= sat_add(r_acc_re, r_term_re);
                r_acc_im <= sat_add(r_acc_im, r_term_im);
            end else if (r_state == ST_MAG) begin
                r_acc_re <= '0;
                r_acc_im <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_sin  <= pwps_pkg::sine_at(i_q_item.addr);
                    r_cos  <= pwps_pkg::sine_at(i_q_item.addr
                              + pwps_pkg::TAB_ADDR_BITS'(pwps_pkg::QUARTER));
                    r_wr   <= i_q_item.coef_real;
                    r_wi   <= i_q_item.coef_imag;
                    r_ov   <= i_q_item.overlap;
                    r_last <= i_q_item.last;
                end
            end
            ST_MUL: begin
                r_p_cr <= r_cos * r_wr;
                r_p_si <= r_sin * r_wi;
                r_p_sr <= r_sin * r_wr;
                r_p_ci <= r_cos * r_wi;
            end
            ST_RND: begin
                r_tr <= rot_re[P2_BITS:FRAC];
                r_ti <= rot_im[P2_BITS:FRAC];
            end
            ST_TERM: begin
                r_term_re <= r_tr * r_ov;
                r_term_im <= r_ti * r_ov;
            end
            ST_MAG: begin
                r_neg_re <= r_acc_re[ACCB-1];
                r_neg_im <= r_acc_im[ACCB-1];
                r_mag_re <= r_acc_re[ACCB-1] ? -r_acc_re : r_acc_re;
                r_mag_im <= r_acc_im[ACCB-1] ? -r_acc_im : r_acc_im;
            end
            ST_NMUL: begin
                r_ph_re <= r_mag_re[ACCB-1:SPLIT] * i_norm_scale;
                r_pl_re <= r_mag_re[SPLIT-1:0] * i_norm_scale;
                r_ph_im <= r_mag_im[ACCB-1:SPLIT] * i_norm_scale;
                r_pl_im <= r_mag_im[SPLIT-1:0] * i_norm_scale;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_res.sum_real <= sc_re[SUMB-1:0];
                    r_res.sum_imag <= sc_im[SUMB-1:0];
                    r_res.overflow <= sc_re[SUMB] | sc_im[SUMB];
                end
            end
            default: ;
        endcase
    end

    `PWPS_ASSERT_NEXT(a_acc_clr, r_state == ST_MAG, r_acc_re == '0 && r_acc_im == '0, "sums not cleared after last")
    `PWPS_ASSERT_NOW(a_res_src, $rose(r_res_valid), $past(r_state) == ST_OUT, "result raised outside output step")
    `PWPS_ASSERT_NEXT(a_res_hold, r_state == ST_OUT && r_res_valid && !i_res_ready, r_state == ST_OUT, "pending result overwritten")

endmodule

### design/phase_weighted_projection_sum_core.sv
// channel  dir  payload, lowest bits first                                 handshake
// s_axis   in   tdata: coef_real, coef_imag, overlap, cell_a, cell_b,      tvalid/tready
//               cell_c, zero pad; tlast: last
// m_axis   out  tdata: sum_real, sum_imag; tuser: overflow                 tvalid/tready
// cfg      in   i_cfg_addr 0..3: kpoint_a, kpoint_b, kpoint_c, norm_scale  i_cfg_we
//
// front stage takes one request per cycle until its 4-entry queue fills
// the back sequencer takes a term through its idle, mul, rnd, term and acc states, and a term
// with tlast also through mag, nmul and out; it takes a new request only in its idle state
// m_axis backpressure only holds a last term in its output step; other terms go on
// reset is synchronous active low: sums cleared, k-point 0, norm_scale 1.0
module phase_weighted_projection_sum_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // coef_real, coef_imag, overlap, cell_a, cell_b, cell_c
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // sum_real, sum_imag
    output logic        m_axis_tuser,   // overflow
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    localparam int OPB  = pwps_pkg::OPERAND_BITS;
    localparam int CB   = pwps_pkg::CELL_BITS;

    localparam logic [1:0] CFG_KPOINT_A   = 2'd0;
    localparam logic [1:0] CFG_KPOINT_B   = 2'd1;
    localparam logic [1:0] CFG_KPOINT_C   = 2'd2;
    localparam logic [1:0] CFG_NORM_SCALE = 2'd3;

    localparam logic [pwps_pkg::NORM_BITS-1:0] NORM_ONE =
        pwps_pkg::NORM_BITS'(2 ** pwps_pkg::NORM_FRAC);

    logic signed [pwps_pkg::KPOINT_BITS-1:0] r_kpoint_a;
    logic signed [pwps_pkg::KPOINT_BITS-1:0] r_kpoint_b;
    logic signed [pwps_pkg::KPOINT_BITS-1:0] r_kpoint_c;
    logic [pwps_pkg::NORM_BITS-1:0]          r_norm_scale;

    pwps_pkg::t_in_item in_item;
    pwps_pkg::t_fe_item fe_item;
    pwps_pkg::t_fe_item q_item;
    pwps_pkg::t_result  res;
    logic               fe_valid;
    logic               fe_ready;
    logic               q_valid;
    logic               q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kpoint_a   <= '0;
            r_kpoint_b   <= '0;
            r_kpoint_c   <= '0;
            r_norm_scale <= NORM_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_KPOINT_A:   r_kpoint_a   <= i_cfg_data;
                CFG_KPOINT_B:   r_kpoint_b   <= i_cfg_data;
                CFG_KPOINT_C:   r_kpoint_c   <= i_cfg_data;
                CFG_NORM_SCALE: r_norm_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item.coef_real = s_axis_tdata[OPB-1:0];
        in_item.coef_imag = s_axis_tdata[2*OPB-1:OPB];
        in_item.overlap   = s_axis_tdata[3*OPB-1:2*OPB];
        in_item.cell_a    = s_axis_tdata[3*OPB+CB-1:3*OPB];
        in_item.cell_b    = s_axis_tdata[3*OPB+2*CB-1:3*OPB+CB];
        in_item.cell_c    = s_axis_tdata[3*OPB+3*CB-1:3*OPB+2*CB];
        in_item.last      = s_axis_tlast;
    end

    pwps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (in_item),
        .i_kpoint_a (r_kpoint_a),
        .i_kpoint_b (r_kpoint_b),
        .i_kpoint_c (r_kpoint_c),
        .o_valid    (fe_valid),
        .i_ready    (fe_ready),
        .o_item     (fe_item)
    );

    pwps_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_item  (fe_item),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_item  (q_item)
    );

    pwps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_item     (q_item),
        .i_norm_scale (r_norm_scale),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (res)
    );

    assign m_axis_tdata = {res.sum_imag, res.sum_real};
    assign m_axis_tuser = res.overflow;

endmodule
